// ----- design/fdm_pkg.sv -----
// Package for the floppy drive mechanism: command codes, field widths and
// the control and status structs shared by the serial rescale units.
// No dependencies.
package fdm_pkg;

   localparam int unsigned LenWidth  = 16;
   localparam int unsigned ProdWidth = 2 * LenWidth;
   localparam int unsigned CylWidth  = 8;
   localparam int unsigned SpinWidth = 20;
   localparam int unsigned TpbWidth  = 8;
   localparam int unsigned TurnWidth = 32;
   localparam int unsigned ReqWidth  = 40;
   localparam int unsigned RspWidth  = 32;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 20;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_MOTOR  = 3'd2,
      CMD_SIDE   = 3'd3,
      CMD_STEP   = 3'd4
   } cmd_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TWO_HEADS      = 2'd0,
      CSR_SPIN_UP_TICKS  = 2'd1,
      CSR_TICKS_PER_BYTE = 2'd2
   } csr_idx_type;

   localparam logic [TpbWidth-1:0] TpbReset = 8'd32;

   typedef struct packed {
      logic start;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

// ----- design/floppy_drive_mechanism.sv -----
// Top level of the floppy drive mechanism: command decode, drive state,
// response register and the serial position rescale. Depends on fdm_pkg,
// fdm_mul and fdm_div.
//
// One response per request, reporting the drive state after the command.
// Tick, insert/eject, motor, side, unknown commands and steps that need no
// rescale load the response straight from the idle state. A step that moves
// the head with a medium inserted and a non-zero current track length
// rescales the byte position through a bit-serial multiplier and then a
// restoring divider, which finishes at once when the result saturates. A
// new request is taken only once the previous response has gone, at the
// earliest in the cycle that response is taken.
module floppy_drive_mechanism
   import fdm_pkg::*;
#(
   parameter int unsigned MAX_CYL = 84
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // arg_bit, medium_write_protect, current_track_length, target_track_length
   input  logic [ReqWidth-1:0]     req_tdata,
   // cmd
   input  logic [2:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // mech_ready, at_track_zero, protected_medium, double_sided, index_pulse,
   // head_cylinder, head_side, angle_byte
   output logic [RspWidth-1:0]     rsp_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   localparam logic [CylWidth-1:0] CylLast = CylWidth'(MAX_CYL - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic                   two_heads_ff, two_heads_in;
   logic [SpinWidth-1:0]   spin_up_ff, spin_up_in;
   logic [TpbWidth-1:0]    tpb_ff, tpb_in;
   logic                   disk_in_ff, disk_in_in;
   logic                   wp_ff, wp_in;
   logic                   motor_ff, motor_in;
   logic [SpinWidth-1:0]   spin_ff, spin_in;
   logic                   side_ff, side_in;
   logic [CylWidth-1:0]    cyl_ff, cyl_in;
   logic [LenWidth-1:0]    pos_ff, pos_in;
   logic [TpbWidth-1:0]    timer_ff, timer_in;
   logic [TurnWidth-1:0]   turn_ff, turn_in;
   logic                   flag_ff, flag_in;
   logic [LenWidth-1:0]    len_ff, len_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RspWidth-1:0]    rsp_data_ff, rsp_data_in;

   cmd_type                cmd;
   logic                   arg;
   logic                   req_wp;
   logic [LenWidth-1:0]    cur_len;
   logic [LenWidth-1:0]    tgt_len;
   logic                   accept;
   logic                   out_free;
   logic                   rescale;
   logic                   load_rsp;
   logic [TpbWidth-1:0]    timer_inc;
   logic [LenWidth:0]      pos_next;
   logic [CylWidth-1:0]    cyl_step;
   unit_ctl_type           mul_ctl, div_ctl;
   unit_sts_type           mul_sts, div_sts;
   logic [ProdWidth-1:0]   product;
   logic [LenWidth-1:0]    quotient;

   assign cmd     = cmd_type'(req_tuser);
   assign arg     = req_tdata[0];
   assign req_wp  = req_tdata[1];
   assign cur_len = req_tdata[17:2];
   assign tgt_len = req_tdata[33:18];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      two_heads_in = two_heads_ff;
      spin_up_in   = spin_up_ff;
      tpb_in       = tpb_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TWO_HEADS:      two_heads_in = csr_data[0];
            CSR_SPIN_UP_TICKS:  spin_up_in   = csr_data;
            CSR_TICKS_PER_BYTE: tpb_in       = csr_data[TpbWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      disk_in_in = disk_in_ff;
      wp_in      = wp_ff;
      motor_in   = motor_ff;
      spin_in    = spin_ff;
      side_in    = side_ff;
      cyl_in     = cyl_ff;
      pos_in     = pos_ff;
      timer_in   = timer_ff;
      turn_in    = turn_ff;
      flag_in    = flag_ff;
      len_in     = len_ff;
      rescale    = 1'b0;
      load_rsp   = 1'b0;
      mul_ctl.start = 1'b0;
      div_ctl.start = 1'b0;
      timer_inc  = timer_ff + 1'b1;
      pos_next   = {1'b0, pos_ff} + 1'b1;
      cyl_step   = cyl_ff;
      if (arg) begin
         if (cyl_ff < CylLast) cyl_step = cyl_ff + 1'b1;
      end else if (cyl_ff != '0) begin
         cyl_step = cyl_ff - 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_TICK: begin
                     flag_in = 1'b0;
                     if (motor_ff && disk_in_ff) begin
                        if (spin_ff != '0) spin_in = spin_ff - 1'b1;
                        if (timer_inc < tpb_ff) begin
                           timer_in = timer_inc;
                        end else begin
                           timer_in = '0;
                           flag_in  = 1'b1;
                           if (pos_next >= {1'b0, cur_len}) begin
                              pos_in  = '0;
                              turn_in = turn_ff + 1'b1;
                           end else begin
                              pos_in = pos_next[LenWidth-1:0];
                           end
                        end
                     end
                  end
                  CMD_INSERT: begin
                     disk_in_in = arg;
                     wp_in      = req_wp;
                     pos_in     = '0;
                     turn_in    = '0;
                     timer_in   = '0;
                     flag_in    = 1'b0;
                  end
                  CMD_MOTOR: begin
                     if (arg && !motor_ff) spin_in = spin_up_ff;
                     if (!arg) flag_in = 1'b0;
                     motor_in = arg;
                  end
                  CMD_SIDE: side_in = two_heads_ff && arg;
                  CMD_STEP: begin
                     cyl_in = cyl_step;
                     if (disk_in_ff && cyl_step != cyl_ff) begin
                        if (cur_len == '0) begin
                           pos_in = '0;
                        end else begin
                           rescale = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
               if (rescale) begin
                  len_in        = cur_len;
                  mul_ctl.start = 1'b1;
                  state_in      = ST_MUL;
               end else begin
                  load_rsp = 1'b1;
               end
            end
         end
         ST_MUL: begin
            if (mul_sts.done) begin
               div_ctl.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               pos_in   = quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_data_in = {2'b00,
                         pos_in,
                         side_in,
                         cyl_in,
                         flag_in && (pos_in == '0),
                         two_heads_in,
                         disk_in_in && wp_in,
                         cyl_in == '0,
                         disk_in_in && motor_in && (spin_in == '0)};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         two_heads_ff <= 1'b0;
         spin_up_ff   <= '0;
         tpb_ff       <= TpbReset;
         disk_in_ff   <= 1'b0;
         wp_ff        <= 1'b0;
         motor_ff     <= 1'b0;
         spin_ff      <= '0;
         side_ff      <= 1'b0;
         cyl_ff       <= '0;
         pos_ff       <= '0;
         timer_ff     <= '0;
         turn_ff      <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         two_heads_ff <= two_heads_in;
         spin_up_ff   <= spin_up_in;
         tpb_ff       <= tpb_in;
         disk_in_ff   <= disk_in_in;
         wp_ff        <= wp_in;
         motor_ff     <= motor_in;
         spin_ff      <= spin_in;
         side_ff      <= side_in;
         cyl_ff       <= cyl_in;
         pos_ff       <= pos_in;
         timer_ff     <= timer_in;
         turn_ff      <= turn_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff <= len_in;
      if (load_rsp) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   fdm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .mcand   (pos_ff),
      .mplier  (tgt_len),
      .sts     (mul_sts),
      .product (product)
   );

   fdm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (product),
      .divisor  (len_ff),
      .sts      (div_sts),
      .quotient (quotient)
   );

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_sts.busy && div_sts.busy))
      else $error("multiplier and divider busy together");

   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mul_sts.busy && !div_sts.busy)
      else $error("rescale unit busy while idle");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIV)
      else $error("divider finished outside its phase");

endmodule

// ----- design/fdm_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on fdm_pkg.
module fdm_mul
   import fdm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  unit_ctl_type         ctl,
   input  logic [LenWidth-1:0]  mcand,
   input  logic [LenWidth-1:0]  mplier,
   output unit_sts_type         sts,
   output logic [ProdWidth-1:0] product
);

   localparam int unsigned CntWidth = $clog2(LenWidth);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic [ProdWidth-1:0] prod_ff, prod_in;
   logic [LenWidth-1:0]  mcand_ff, mcand_in;
   logic [LenWidth:0]    sum;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      sum = {1'b0, prod_ff[ProdWidth-1:LenWidth]}
            + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      if (ctl.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         prod_in  = {{LenWidth{1'b0}}, mplier};
         mcand_in = mcand;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[LenWidth-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(LenWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = prod_ff;

endmodule

// ----- design/fdm_div.sv -----
// Restoring divider, one quotient bit per cycle, saturating at all ones.
// Depends on fdm_pkg.
module fdm_div
   import fdm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  unit_ctl_type         ctl,
   input  logic [ProdWidth-1:0] dividend,
   input  logic [LenWidth-1:0]  divisor,
   output unit_sts_type         sts,
   output logic [LenWidth-1:0]  quotient
);

   localparam int unsigned CntWidth = $clog2(LenWidth);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                sat_ff, sat_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [LenWidth-1:0] rem_ff, rem_in;
   logic [LenWidth-1:0] quo_ff, quo_in;
   logic [LenWidth-1:0] dsr_ff, dsr_in;
   logic [LenWidth:0]   trial;
   logic [LenWidth:0]   diff;
   logic                fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial = {rem_ff, quo_ff[LenWidth-1]};
      fits  = trial >= {1'b0, dsr_ff};
      diff  = trial - {1'b0, dsr_ff};
      if (ctl.start) begin
         sat_in = dividend[ProdWidth-1:LenWidth] >= divisor;
         rem_in = dividend[ProdWidth-1:LenWidth];
         quo_in = dividend[LenWidth-1:0];
         dsr_in = divisor;
         cnt_in = '0;
         if (dividend[ProdWidth-1:LenWidth] >= divisor) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[LenWidth-1:0] : trial[LenWidth-1:0];
         quo_in = {quo_ff[LenWidth-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(LenWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = sat_ff ? '1 : quo_ff;

endmodule
